>>> hdl/shfp_pkg.sv
`timescale 1ns / 1ps

package shfp_pkg;

	// magic and check lengths, in bytes
	localparam logic [2:0] HDR_MAGIC_LEN = 3'd6;
	localparam logic [2:0] FTR_MAGIC_LEN = 3'd2;
	localparam logic [2:0] CRC_LEN       = 3'd4;

	localparam int HDR_MAGIC_W = 48;
	localparam int FTR_MAGIC_W = 16;

	// flags byte fields and the crc-32 polynomial
	localparam logic [7:0] FLAGS_RSVD_MASK = 8'hE0;
	localparam logic [31:0] CRC_POLY       = 32'hEDB88320;

	// configuration port
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 64;

	typedef enum logic [1:0] {
		REG_TAIL_MODE    = 2'd0,
		REG_HEADER_MAGIC = 2'd1,
		REG_FOOTER_MAGIC = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_FINISHED = 3'd1,
		ST_DATA_ERR = 3'd2,
		ST_HDR_ERR  = 3'd3,
		ST_IDLE     = 3'd4
	} status_t;

	typedef struct packed {
		logic                   tail_mode;
		logic [HDR_MAGIC_W-1:0] header_magic;
		logic [FTR_MAGIC_W-1:0] footer_magic;
	} cfg_t;

	typedef struct packed {
		logic       flags_seen;
		logic       multi_stream;
		logic       has_crc;
		logic [2:0] check_type;
		status_t    status;
	} result_t;

	// reflected crc-32 of a single byte, with initial and final inversion
	function automatic logic [31:0] crc32_byte(input logic [7:0] b);
		logic [31:0] c;
		c = 32'hFFFF_FFFF ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return ~c;
	endfunction

endpackage

>>> hdl/shfp_cfg.sv
`timescale 1ns / 1ps

module shfp_cfg
	import shfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic     tail_mode_q;
	logic [HDR_MAGIC_W-1:0] header_magic_q;
	logic [FTR_MAGIC_W-1:0] footer_magic_q;
	logic     wr_en;
	reg_idx_t reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_mode_q    <= 1'b0;
			header_magic_q <= '0;
			footer_magic_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_TAIL_MODE:    tail_mode_q    <= pwdata[0];
				REG_HEADER_MAGIC: header_magic_q <= pwdata[HDR_MAGIC_W-1:0];
				REG_FOOTER_MAGIC: footer_magic_q <= pwdata[FTR_MAGIC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TAIL_MODE:    prdata = {{(CFG_DW-1){1'b0}}, tail_mode_q};
			REG_HEADER_MAGIC: prdata = {{(CFG_DW-HDR_MAGIC_W){1'b0}}, header_magic_q};
			REG_FOOTER_MAGIC: prdata = {{(CFG_DW-FTR_MAGIC_W){1'b0}}, footer_magic_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg.tail_mode    = tail_mode_q;
	assign cfg.header_magic = header_magic_q;
	assign cfg.footer_magic = footer_magic_q;

endmodule

>>> hdl/shfp_core.sv
`timescale 1ns / 1ps

module shfp_core
	import shfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       step_en,
	input  logic [7:0] in_byte,
	input  logic       begin_req,
	output result_t    res
);

	typedef enum logic [2:0] {
		PH_HDR_MAGIC  = 3'd0,
		PH_HDR_FLAGS  = 3'd1,
		PH_HDR_CRC    = 3'd2,
		PH_TAIL_FLAGS = 3'd3,
		PH_TAIL_MAGIC = 3'd4
	} phase_t;

	phase_t      phase_q, ph_d;
	logic [2:0]  byte_idx_q, idx_d;
	logic [31:0] flags_crc_q, crc_d;
	logic [4:0]  latched_flags_q, lf_d;
	logic        halted_q, hlt_d;
	status_t     st;

	logic [HDR_MAGIC_W-1:0] hdr_sh;
	logic [FTR_MAGIC_W-1:0] ftr_sh;
	logic [31:0]            crc_sh;
	logic                   flags_ok;

	// byte select by shift; index is range-checked before use
	assign hdr_sh   = cfg.header_magic >> {byte_idx_q, 3'b000};
	assign ftr_sh   = cfg.footer_magic >> {byte_idx_q, 3'b000};
	assign crc_sh   = flags_crc_q >> {byte_idx_q, 3'b000};
	assign flags_ok = (in_byte & FLAGS_RSVD_MASK) == 8'h00;

	always_comb begin
		ph_d  = phase_q;
		idx_d = byte_idx_q;
		crc_d = flags_crc_q;
		lf_d  = latched_flags_q;
		hlt_d = halted_q;
		st    = ST_OK;

		if (begin_req) begin
			ph_d  = cfg.tail_mode ? PH_TAIL_FLAGS : PH_HDR_MAGIC;
			idx_d = '0;
			crc_d = '0;
			lf_d  = '0;
			hlt_d = 1'b0;
		end

		// after begin, the counters seen below are all zero
		if (hlt_d) begin
			st = ST_IDLE;
		end else begin
			case (ph_d)
				PH_HDR_MAGIC: begin
					if (idx_d >= HDR_MAGIC_LEN ||
					    in_byte != (begin_req ? cfg.header_magic[7:0] : hdr_sh[7:0])) begin
						st = ST_DATA_ERR;
					end else if (idx_d + 3'd1 == HDR_MAGIC_LEN) begin
						idx_d = '0;
						ph_d  = PH_HDR_FLAGS;
					end else begin
						idx_d = idx_d + 3'd1;
					end
				end
				PH_HDR_FLAGS: begin
					if (!flags_ok) begin
						st = ST_HDR_ERR;
					end else begin
						lf_d  = in_byte[4:0];
						crc_d = crc32_byte(in_byte);
						ph_d  = PH_HDR_CRC;
					end
				end
				PH_HDR_CRC: begin
					if (idx_d >= CRC_LEN || in_byte != crc_sh[7:0]) begin
						st = ST_DATA_ERR;
					end else begin
						idx_d = idx_d + 3'd1;
						if (idx_d == CRC_LEN)
							st = ST_FINISHED;
					end
				end
				PH_TAIL_FLAGS: begin
					if (!flags_ok) begin
						st = ST_HDR_ERR;
					end else begin
						lf_d = in_byte[4:0];
						ph_d = PH_TAIL_MAGIC;
					end
				end
				PH_TAIL_MAGIC: begin
					if (idx_d >= FTR_MAGIC_LEN || in_byte != ftr_sh[7:0]) begin
						st = ST_DATA_ERR;
					end else begin
						idx_d = idx_d + 3'd1;
						if (idx_d == FTR_MAGIC_LEN)
							st = ST_FINISHED;
					end
				end
				default: st = ST_DATA_ERR;
			endcase
			if (st != ST_OK)
				hlt_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_HDR_MAGIC;
			byte_idx_q      <= '0;
			flags_crc_q     <= '0;
			latched_flags_q <= '0;
			halted_q        <= 1'b0;
		end else if (step_en) begin
			phase_q         <= ph_d;
			byte_idx_q      <= idx_d;
			flags_crc_q     <= crc_d;
			latched_flags_q <= lf_d;
			halted_q        <= hlt_d;
		end
	end

	assign res.status       = st;
	assign res.check_type   = lf_d[2:0];
	assign res.has_crc      = lf_d[3];
	assign res.multi_stream = lf_d[4];
	assign res.flags_seen   = (ph_d == PH_HDR_CRC) || (ph_d == PH_TAIL_MAGIC);

	a_err_halts: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status != ST_OK |=> halted_q)
		else $error("non-ok status did not halt the parser");

	a_idle_only_halted: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && res.status == ST_IDLE |-> halted_q && !begin_req)
		else $error("idle status while parser active");

	a_halted_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && halted_q && !begin_req |=> $stable(latched_flags_q) &&
		$stable(phase_q) && $stable(byte_idx_q))
		else $error("halted parser changed state");

	a_magic_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HDR_MAGIC |-> byte_idx_q < HDR_MAGIC_LEN)
		else $error("header magic index out of range");

endmodule

>>> hdl/stream_header_footer_parser.sv
`timescale 1ns / 1ps

// Checks a stream header (magic, flags byte, crc-32 of the flags byte) or a
// stream tail (flags byte, footer magic), one byte per item, and returns one
// status item per byte. A byte flagged with begin on s_tuser restarts parsing
// in the mode set by tail_mode; after finished or an error every byte reports
// idle until the next begin. Throughput is one byte per clock while the output
// is free: the whole parser state update is combinational between the input
// register and the result register, so each result is shown on m_tdata from the
// result register. Registers are written over APB at byte addresses 0
// (tail_mode), 8 (header_magic) and 16 (footer_magic).
module stream_header_footer_parser
	import shfp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] in_byte
	input  logic              s_tuser,   // [0] begin_req
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [2:0] status, [5:3] check_type, [6] has_crc,
	                                     // [7] multi_stream, [8] flags_seen, [15:9] zero
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	cfg_t       cfg;
	result_t    res;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       begin_s1;
	logic       valid_s2;
	result_t    res_s2;
	logic       out_adv;
	logic       step_en;

	shfp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	shfp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step_en   (step_en),
		.in_byte   (byte_s1),
		.begin_req (begin_s1),
		.res       (res)
	);

	assign out_adv  = !valid_s2 || m_tready;
	assign step_en  = valid_s1 && out_adv;
	assign s_tready = !valid_s1 || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (out_adv)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			begin_s1 <= s_tuser;
		end
		if (step_en)
			res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'b0, res_s2};

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import shfp_pkg::*;

	localparam int RUN_LIMIT = 200000;

	// predicts the status item for every byte and holds the ones still owed
	class parse_tracker;
		typedef enum logic [2:0] {
			S_MAGIC,
			S_FLAGS,
			S_CRC,
			S_TFLAGS,
			S_TMAGIC
		} step_t;

		logic                   tail_mode;
		logic [HDR_MAGIC_W-1:0] hdr_magic;
		logic [FTR_MAGIC_W-1:0] ftr_magic;
		step_t                  step;
		int unsigned            pos;
		logic [31:0]            want_crc;
		logic [4:0]             flags;
		logic                   halted;
		result_t                owed[$];
		int                     mismatches;

		function new();
			tail_mode  = 1'b0;
			hdr_magic  = '0;
			ftr_magic  = '0;
			step       = S_MAGIC;
			pos        = 0;
			want_crc   = '0;
			flags      = '0;
			halted     = 1'b0;
			mismatches = 0;
		endfunction

		// bitwise reflected crc-32 of one byte
		static function logic [31:0] crc_of_flags(logic [7:0] b);
			logic [31:0] r;
			logic        fb;
			r = '1;
			for (int k = 0; k < 8; k++) begin
				fb = r[0] ^ b[k];
				r  = r >> 1;
				if (fb)
					r = r ^ CRC_POLY;
			end
			return ~r;
		endfunction

		function void set_reg(reg_idx_t idx, logic [CFG_DW-1:0] v);
			case (idx)
				REG_TAIL_MODE:    tail_mode = v[0];
				REG_HEADER_MAGIC: hdr_magic = v[HDR_MAGIC_W-1:0];
				REG_FOOTER_MAGIC: ftr_magic = v[FTR_MAGIC_W-1:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return owed.size();
		endfunction

		function void note_byte(logic [7:0] b, logic restart);
			status_t st;
			result_t r;
			st = ST_OK;
			if (restart) begin
				step     = tail_mode ? S_TFLAGS : S_MAGIC;
				pos      = 0;
				want_crc = '0;
				flags    = '0;
				halted   = 1'b0;
			end
			if (halted) begin
				st = ST_IDLE;
			end else begin
				case (step)
					S_MAGIC: begin
						if (b != hdr_magic[8*pos +: 8]) begin
							st = ST_DATA_ERR;
						end else begin
							pos++;
							if (pos == HDR_MAGIC_LEN) begin
								pos  = 0;
								step = S_FLAGS;
							end
						end
					end
					S_FLAGS: begin
						if ((b & FLAGS_RSVD_MASK) != 0) begin
							st = ST_HDR_ERR;
						end else begin
							flags    = b[4:0];
							want_crc = crc_of_flags(b);
							step     = S_CRC;
						end
					end
					S_CRC: begin
						if (b != want_crc[8*pos +: 8]) begin
							st = ST_DATA_ERR;
						end else begin
							pos++;
							if (pos == CRC_LEN)
								st = ST_FINISHED;
						end
					end
					S_TFLAGS: begin
						if ((b & FLAGS_RSVD_MASK) != 0) begin
							st = ST_HDR_ERR;
						end else begin
							flags = b[4:0];
							step  = S_TMAGIC;
						end
					end
					S_TMAGIC: begin
						if (b != ftr_magic[8*pos +: 8]) begin
							st = ST_DATA_ERR;
						end else begin
							pos++;
							if (pos == FTR_MAGIC_LEN)
								st = ST_FINISHED;
						end
					end
					default: st = ST_DATA_ERR;
				endcase
				if (st != ST_OK)
					halted = 1'b1;
			end
			r.status       = st;
			r.check_type   = flags[2:0];
			r.has_crc      = flags[3];
			r.multi_stream = flags[4];
			r.flags_seen   = (step == S_CRC || step == S_TMAGIC);
			owed.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(logic [15:0] data);
			result_t got;
			result_t want;
			got = result_t'(data[8:0]);
			if (owed.size() == 0) begin
				$error("status item 0x%h with no byte outstanding", data);
				mismatches++;
				return;
			end
			want = owed.pop_front();
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("check_type", 8'(want.check_type), 8'(got.check_type));
			compare_field("has_crc", 8'(want.has_crc), 8'(got.has_crc));
			compare_field("multi_stream", 8'(want.multi_stream), 8'(got.multi_stream));
			compare_field("flags_seen", 8'(want.flags_seen), 8'(got.flags_seen));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [7:0] in_byte
	logic              s_tuser;   // [0] begin_req
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;   // [2:0] status, [5:3] check_type, [6] has_crc,
	                              // [7] multi_stream, [8] flags_seen, [15:9] zero
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [CFG_AW-1:0] paddr;
	logic [CFG_DW-1:0] pwdata;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	parse_tracker tracker = new();

	int          bytes_sent  = 0;
	int          burst_left  = 0;
	int unsigned cycle_count = 0;
	int          stall_mode  = 0;
	int          stall_left  = 0;
	logic [15:0] stall_bits  = 16'hFFFF;

	stream_header_footer_parser uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	// receiver: always ready, a repeating 16-bit mask indexed by the cycle counter, or random stalls
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_bits <= 16'($urandom) | 16'h0001;
			stall_left <= $urandom_range(50, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= stall_bits[cycle_count[3:0]];
			default: m_tready <= ($urandom_range(0, 2) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				tracker.note_byte(s_tdata, s_tuser);
			if (m_tvalid && m_tready)
				tracker.check_result(m_tdata);
		end
	end

	task automatic push_byte(logic [7:0] b, logic restart);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tuser  <= restart;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [CFG_DW-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, v);
		@(posedge clk);
	endtask

	// sends a header or tail built from the current magic values; one byte may be
	// corrupted and the sequence may be cut short
	task automatic send_frame(logic as_tail, logic restart, logic [7:0] fl, int bad_at,
		int keep);
		logic [7:0]  seq[$];
		logic [31:0] crc;
		int          n;
		if (as_tail) begin
			seq.push_back(fl);
			for (int k = 0; k < FTR_MAGIC_LEN; k++)
				seq.push_back(tracker.ftr_magic[8*k +: 8]);
		end else begin
			for (int k = 0; k < HDR_MAGIC_LEN; k++)
				seq.push_back(tracker.hdr_magic[8*k +: 8]);
			seq.push_back(fl);
			crc = parse_tracker::crc_of_flags(fl);
			for (int k = 0; k < CRC_LEN; k++)
				seq.push_back(crc[8*k +: 8]);
		end
		if (bad_at >= 0 && bad_at < seq.size())
			seq[bad_at] = seq[bad_at] ^ 8'($urandom_range(1, 255));
		n = (keep < 0 || keep > seq.size()) ? seq.size() : keep;
		for (int k = 0; k < n; k++)
			push_byte(seq[k], restart && k == 0);
	endtask

	task automatic pick_setting();
		logic [HDR_MAGIC_W-1:0] hm;
		logic [FTR_MAGIC_W-1:0] fm;
		case ($urandom_range(0, 3))
			0:       hm = '0;
			1:       hm = '1;
			default: hm = HDR_MAGIC_W'({$urandom, $urandom});
		endcase
		case ($urandom_range(0, 3))
			0:       fm = '0;
			1:       fm = '1;
			default: fm = FTR_MAGIC_W'($urandom);
		endcase
		wait_idle();
		reg_write(REG_TAIL_MODE, CFG_DW'($urandom_range(0, 1)));
		reg_write(REG_HEADER_MAGIC, CFG_DW'(hm));
		reg_write(REG_FOOTER_MAGIC, CFG_DW'(fm));
	endtask

	task automatic random_frame();
		int         roll;
		int         len;
		int         bad;
		int         keep;
		logic [7:0] fl;
		roll = $urandom_range(0, 99);
		if (roll < 15) begin
			// noise, with the odd restart in it
			repeat ($urandom_range(1, 8))
				push_byte(8'($urandom), ($urandom_range(0, 7) == 0));
		end else begin
			fl   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 31));
			len  = tracker.tail_mode ? 1 + FTR_MAGIC_LEN : HDR_MAGIC_LEN + 1 + CRC_LEN;
			bad  = -1;
			keep = -1;
			if ($urandom_range(0, 3) == 0)
				bad = $urandom_range(0, len - 1);
			if (roll >= 85)
				keep = $urandom_range(1, len - 1);
			send_frame(tracker.tail_mode, 1'b1, fl, bad, keep);
			repeat ($urandom_range(0, 2))
				push_byte(8'($urandom), 1'b0);
		end
	endtask

	initial begin
		int next_setting;
		int stop_at;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tail mode set but no restart yet: still parses a header
		reg_write(REG_TAIL_MODE, CFG_DW'(1));
		reg_write(REG_HEADER_MAGIC, CFG_DW'({HDR_MAGIC_W{1'b1}}));
		reg_write(REG_FOOTER_MAGIC, '0);
		send_frame(1'b0, 1'b0, 8'h1F, -1, -1);
		push_byte(8'h00, 1'b0);
		send_frame(1'b1, 1'b1, 8'hE0, -1, 1);
		send_frame(1'b1, 1'b1, 8'h00, -1, -1);
		send_frame(1'b1, 1'b1, 8'h15, 2, -1);

		wait_idle();
		reg_write(REG_TAIL_MODE, '0);
		reg_write(REG_HEADER_MAGIC, CFG_DW'(HDR_MAGIC_W'({$urandom, $urandom})));
		reg_write(REG_FOOTER_MAGIC, CFG_DW'({FTR_MAGIC_W{1'b1}}));
		send_frame(1'b0, 1'b1, 8'h0A, 0, 1);
		send_frame(1'b0, 1'b1, 8'h80, -1, 7);

		stop_at      = bytes_sent + 600;
		next_setting = bytes_sent;
		while (bytes_sent < stop_at) begin
			if (bytes_sent >= next_setting) begin
				pick_setting();
				next_setting = bytes_sent + $urandom_range(50, 90);
			end
			random_frame();
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (tracker.pending() != 0)
			$error("%0d status items never arrived", tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
